@@ rtl/usbcds_pkg.sv @@
package usbcds_pkg;

  localparam logic [7:0] DescTypeInterface = 8'h04;
  localparam logic [7:0] DescTypeEndpoint  = 8'h05;
  localparam logic [7:0] MidiClass         = 8'h01;
  localparam logic [7:0] MidiSubclass      = 8'h03;
  localparam logic [7:0] MidiProtocol      = 8'h00;
  localparam logic [1:0] XferTypeBulk      = 2'h2;
  localparam logic [7:0] IfMinLength       = 8'd8;
  localparam logic [7:0] EpMinLength       = 8'd6;
  localparam logic [15:0] MinTotalLength   = 16'd4;
  localparam int NumCaptured = 6;

  // Packed so that midi_seen sits in the lowest bit.
  typedef struct packed {
    logic        malformed;
    logic [15:0] out_max_packet;
    logic [6:0]  out_endpoint;
    logic [15:0] in_max_packet;
    logic [6:0]  in_endpoint;
    logic        midi_seen;
  } summary_t;

  localparam int SummaryWidth = $bits(summary_t);

endpackage

@@ rtl/usbcds_walker.sv @@
module usbcds_walker (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                start_of_set,
  output logic                res_valid,
  output usbcds_pkg::summary_t res
);
  import usbcds_pkg::*;

  logic [15:0] total_length, total_length_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [7:0]  offset, offset_next;
  logic [7:0]  desc_length, desc_length_next;
  logic [7:0]  desc_type, desc_type_next;
  logic [7:0]  captured [NumCaptured];
  logic [7:0]  captured_next [NumCaptured];
  logic        found, found_next;
  logic        active, active_next;
  logic        bad, bad_next;
  logic [6:0]  in_ep, in_ep_next;
  logic [15:0] in_size, in_size_next;
  logic [6:0]  out_ep, out_ep_next;
  logic [15:0] out_size, out_size_next;

  always_comb begin
    logic        stop;
    logic        done;
    logic [2:0]  cidx;
    logic [15:0] seen_inc;
    total_length_next = total_length;
    bytes_seen_next   = bytes_seen;
    offset_next       = offset;
    desc_length_next  = desc_length;
    desc_type_next    = desc_type;
    captured_next     = captured;
    found_next        = found;
    active_next       = active;
    bad_next          = bad;
    in_ep_next        = in_ep;
    in_size_next      = in_size;
    out_ep_next       = out_ep;
    out_size_next     = out_size;
    stop              = 1'b0;
    done              = 1'b0;
    cidx              = 3'(offset[2:0] - 3'd2);
    seen_inc          = 16'(bytes_seen + 16'd1);
    if (accept) begin
      if (start_of_set) begin
        total_length_next = '0;
        bytes_seen_next   = '0;
        offset_next       = '0;
        desc_length_next  = '0;
        desc_type_next    = '0;
        for (int i = 0; i < NumCaptured; i++) captured_next[i] = '0;
        found_next        = 1'b0;
        bad_next          = 1'b0;
        active_next       = 1'b1;
        seen_inc          = 16'd1;
      end
      if (active_next) begin
        if (bytes_seen_next == 16'd2) begin
          total_length_next[7:0] = data_byte;
        end else if (bytes_seen_next == 16'd3) begin
          total_length_next[15:8] = data_byte;
        end
        if (!bad_next) begin
          if (offset_next == 8'd0) begin
            if (data_byte == 8'd0) begin
              bad_next = 1'b1;
              stop     = 1'b1;
            end else begin
              desc_length_next = data_byte;
              desc_type_next   = '0;
              for (int i = 0; i < NumCaptured; i++) captured_next[i] = '0;
            end
          end else if (offset_next == 8'd1) begin
            desc_type_next = data_byte;
          end else if (offset_next < 8'd8) begin
            captured_next[cidx] = data_byte;
          end
          if (!stop) begin
            if ({1'b0, offset_next} + 9'd1 >= {1'b0, desc_length_next}) begin
              offset_next = '0;
              if (desc_type_next == DescTypeInterface && desc_length_next >= IfMinLength) begin
                if (captured_next[3] == MidiClass && captured_next[4] == MidiSubclass &&
                    captured_next[5] == MidiProtocol) begin
                  found_next = 1'b1;
                end
              end else if (desc_type_next == DescTypeEndpoint &&
                           desc_length_next >= EpMinLength) begin
                if (captured_next[1][1:0] == XferTypeBulk) begin
                  if (captured_next[0][7]) begin
                    in_ep_next   = captured_next[0][6:0];
                    in_size_next = {captured_next[3], captured_next[2]};
                  end else begin
                    out_ep_next   = captured_next[0][6:0];
                    out_size_next = {captured_next[3], captured_next[2]};
                  end
                end
              end
            end else begin
              offset_next = 8'(offset_next + 8'd1);
            end
          end
        end
        if (bytes_seen_next >= 16'd3) begin
          if (total_length_next < MinTotalLength) begin
            bad_next = 1'b1;
            done     = 1'b1;
          end else if (seen_inc == total_length_next) begin
            done = 1'b1;
          end
        end
        bytes_seen_next = seen_inc;
        if (done) begin
          if (offset_next != 8'd0) bad_next = 1'b1;
          active_next = 1'b0;
        end
      end
    end
    res_valid          = done;
    res.midi_seen      = found_next;
    res.in_endpoint    = in_ep_next;
    res.in_max_packet  = in_size_next;
    res.out_endpoint   = out_ep_next;
    res.out_max_packet = out_size_next;
    res.malformed      = bad_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_length <= '0;
      bytes_seen   <= '0;
      offset       <= '0;
      desc_length  <= '0;
      desc_type    <= '0;
      for (int i = 0; i < NumCaptured; i++) captured[i] <= '0;
      found        <= 1'b0;
      active       <= 1'b0;
      bad          <= 1'b0;
      in_ep        <= '0;
      in_size      <= '0;
      out_ep       <= '0;
      out_size     <= '0;
    end else begin
      total_length <= total_length_next;
      bytes_seen   <= bytes_seen_next;
      offset       <= offset_next;
      desc_length  <= desc_length_next;
      desc_type    <= desc_type_next;
      captured     <= captured_next;
      found        <= found_next;
      active       <= active_next;
      bad          <= bad_next;
      in_ep        <= in_ep_next;
      in_size      <= in_size_next;
      out_ep       <= out_ep_next;
      out_size     <= out_size_next;
    end
  end

endmodule

@@ rtl/usbcds_out_buf.sv @@
module usbcds_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  usbcds_pkg::summary_t push_data,
  output logic                 can_push,
  output logic                 out_valid,
  input  logic                 out_ready,
  output usbcds_pkg::summary_t out_data
);
  import usbcds_pkg::*;

  logic     skid_valid;
  summary_t skid_data;
  logic     pop;

  assign pop      = out_valid && out_ready;
  assign can_push = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/usb_config_descriptor_scanner.sv @@
// Takes one descriptor byte per cycle; the walk state updates in the same cycle.
// After the set's last byte the summary is registered in the output or skid slot.
// Throughput is one byte per clock, held off only when both output slots are full.
// Synchronous active-high reset clears the walk state and the endpoint records
// and empties the output slots.
module usb_config_descriptor_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] data_byte
  input  logic        s_tuser,  // [0] start_of_set
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata   // midi_seen, in_endpoint, in_max_packet,
                                // out_endpoint, out_max_packet, malformed
);
  import usbcds_pkg::*;

  logic     s_xfer;
  logic     res_valid;
  summary_t res;
  summary_t out_data;

  assign s_xfer = s_tvalid && s_tready;

  usbcds_walker u_walker (
    .clk          (clk),
    .rst          (rst),
    .accept       (s_xfer),
    .data_byte    (s_tdata),
    .start_of_set (s_tuser),
    .res_valid    (res_valid),
    .res          (res)
  );

  usbcds_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .can_push  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = 48'(out_data);

`ifndef NO_ASSERTIONS
  a_result_needs_transfer: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> s_xfer) else $error("summary without an input transfer");

  a_stall_means_pending: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid) else $error("input stalled with no output pending");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready) else $error("output not empty after reset");

  a_result_shows: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> m_tvalid) else $error("summary did not reach the output");
`endif

endmodule
